// ===== hw/rtl/bfa_pkg.sv =====
// shared types and constants of the best-fit block allocator
// used by bfa_cell and best_fit_block_allocator; no dependencies
package bfa_pkg;

  localparam int unsigned MaxBlocksDef   = 64;
  localparam int unsigned HeaderBytesDef = 16;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_RESIZE = 2'd2,
    OP_QUERY  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_NO_ROOM = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_NOT_NEW = 3'd4
  } status_e;

  localparam logic CfgHeapBase = 1'b0;
  localparam logic CfgHeapEnd  = 1'b1;

  // command broadcast to every cell during a scan
  typedef struct packed {
    op_e         op;
    logic [31:0] size;
    logic [31:0] addr;
  } cmd_t;

  // search word handed from cell to cell
  typedef struct packed {
    logic        found;
    logic        free;
    logic [31:0] size;
    logic [31:0] start;
  } carry_t;

  // entry write bus
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
    logic        free;
  } wr_t;

endpackage

// ===== hw/rtl/bfa_cell.sv =====
// one block table entry with its stage of the search chain
// depends on bfa_pkg
module bfa_cell #(
  parameter int unsigned IW          = 6,
  parameter int unsigned Idx         = 0,
  parameter int unsigned HeaderBytes = bfa_pkg::HeaderBytesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bfa_pkg::cmd_t   cmd_i,
  input  logic            valid_i,
  input  bfa_pkg::carry_t cin_i,
  input  logic [IW-1:0]   cidx_i,
  output bfa_pkg::carry_t cout_o,
  output logic [IW-1:0]   cidx_o,
  input  logic            we_i,
  input  bfa_pkg::wr_t    wr_i
);

  localparam logic [31:0] Hdr = 32'(HeaderBytes);

  logic [31:0] start_q, size_q;
  logic        free_q;
  bfa_pkg::carry_t c_d, c_q;
  logic [IW-1:0]   i_d, i_q;
  logic            take;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      start_q <= wr_i.start;
      size_q  <= wr_i.size;
      free_q  <= wr_i.free;
    end
  end

  // lookup keeps the oldest hit, best fit the smallest with newest on ties
  always_comb begin
    take = 1'b0;
    case (cmd_i.op)
      bfa_pkg::OP_ALLOC: begin
        take = valid_i && free_q && (size_q >= cmd_i.size) &&
               (!cin_i.found || (size_q <= cin_i.size));
      end
      bfa_pkg::OP_FREE, bfa_pkg::OP_RESIZE: begin
        take = valid_i && !cin_i.found && ((start_q + Hdr) == cmd_i.addr);
      end
      default: take = 1'b0;
    endcase
    if (take) begin
      c_d = '{found: 1'b1, free: free_q, size: size_q, start: start_q};
      i_d = IW'(Idx);
    end else begin
      c_d = cin_i;
      i_d = cidx_i;
    end
  end

  // hand the search word on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= '0;
      i_q <= '0;
    end else begin
      c_q <= c_d;
      i_q <= i_d;
    end
  end

  assign cout_o = c_q;
  assign cidx_o = i_q;

endmodule

// ===== hw/rtl/best_fit_block_allocator.sv =====
// best-fit heap allocator top level: control, totals and the cell chain
// depends on bfa_pkg and bfa_cell
//
// Each item walks the row of MAX_BLOCKS entry cells as a search word, one
// cell per cycle; then the done state applies the update and loads the
// result register. One item is worked on at a time; a finished result may
// wait at the output while the next item is taken. Reset leaves no block
// carved; entries are written as blocks are carved, reused, freed or
// resized.
module best_fit_block_allocator #(
  parameter int unsigned MAX_BLOCKS   = bfa_pkg::MaxBlocksDef,
  parameter int unsigned HEADER_BYTES = bfa_pkg::HeaderBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] request_size_i,
  input  logic [31:0] payload_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] result_address_o,
  output logic [2:0]  status_o,
  output logic [31:0] used_bytes_o,
  output logic [31:0] total_bytes_o,
  output logic [6:0]  block_count_o,
  output logic [31:0] reuse_count_o,
  output logic [31:0] resize_count_o
);

  localparam int unsigned IW  = $clog2(MAX_BLOCKS);
  localparam int unsigned CW  = $clog2(MAX_BLOCKS + 1);
  localparam logic [31:0] Hdr = 32'(HEADER_BYTES);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, count_q, count_d;
  logic [31:0] end_q, bump_q, bump_d;
  logic [31:0] used_q, used_d, total_q, total_d, reuse_q, reuse_d, resz_q, resz_d;
  bfa_pkg::cmd_t cmd_q;
  logic out_valid_q;
  logic [31:0] res_d;
  bfa_pkg::status_e st_d;
  logic fin, in_xfer;
  logic [33:0] new_end;

  bfa_pkg::carry_t chain [MAX_BLOCKS+1];
  logic [IW-1:0]   cidx  [MAX_BLOCKS+1];
  logic [MAX_BLOCKS-1:0] cell_we;
  bfa_pkg::wr_t wr;
  logic         we;
  logic [IW-1:0] widx;
  bfa_pkg::carry_t c;

  assign in_xfer    = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign fin = (state_q == S_DONE) && !(out_valid_q && out_stall_i);
  assign chain[0] = '0;
  assign cidx[0]  = '0;
  assign c = chain[MAX_BLOCKS];

  // row of entry cells
  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    bfa_cell #(.IW(IW), .Idx(k), .HeaderBytes(HEADER_BYTES)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd_q),
      .valid_i(CW'(k) < count_q),
      .cin_i  (chain[k]),
      .cidx_i (cidx[k]),
      .cout_o (chain[k+1]),
      .cidx_o (cidx[k+1]),
      .we_i   (cell_we[k]),
      .wr_i   (wr)
    );
    assign cell_we[k] = we && (widx == IW'(k));
  end

  // update once the search word has left the last cell
  always_comb begin
    count_d = count_q;
    bump_d  = bump_q;
    used_d  = used_q;
    total_d = total_q;
    reuse_d = reuse_q;
    resz_d  = resz_q;
    res_d   = '0;
    st_d    = bfa_pkg::ST_OK;
    we      = 1'b0;
    widx    = cidx[MAX_BLOCKS];
    wr      = '{start: c.start, size: c.size, free: c.free};
    new_end = {2'b0, bump_q} + {2'b0, Hdr} + {2'b0, cmd_q.size};
    case (cmd_q.op)
      bfa_pkg::OP_ALLOC: begin
        if (cmd_q.size == '0) begin
          st_d = bfa_pkg::ST_ZERO;
        end else if (c.found) begin
          we      = 1'b1;
          wr.free = 1'b0;
          used_d  = used_q + c.size;
          reuse_d = reuse_q + 32'd1;
          res_d   = c.start + Hdr;
        end else if ((count_q >= CW'(MAX_BLOCKS)) || (new_end > {2'b0, end_q})) begin
          st_d = bfa_pkg::ST_NO_ROOM;
        end else begin
          we      = 1'b1;
          widx    = count_q[IW-1:0];
          wr      = '{start: bump_q, size: cmd_q.size, free: 1'b0};
          count_d = count_q + CW'(1);
          bump_d  = new_end[31:0];
          used_d  = used_q + cmd_q.size;
          total_d = total_q + cmd_q.size;
          res_d   = bump_q + Hdr;
        end
      end
      bfa_pkg::OP_FREE: begin
        if (!c.found) begin
          st_d = bfa_pkg::ST_UNKNOWN;
        end else if (!c.free) begin
          we      = 1'b1;
          wr.free = 1'b1;
          used_d  = used_q - c.size;
        end
      end
      bfa_pkg::OP_RESIZE: begin
        if (!c.found) begin
          st_d = bfa_pkg::ST_UNKNOWN;
        end else if ((CW'(cidx[MAX_BLOCKS]) + CW'(1)) != count_q) begin
          st_d = bfa_pkg::ST_NOT_NEW;
        end else begin
          we      = 1'b1;
          wr.size = cmd_q.size;
          total_d = total_q - c.size + cmd_q.size;
          if (!c.free) used_d = used_q - c.size + cmd_q.size;
          resz_d  = resz_q + 32'd1;
        end
      end
      default: ;
    endcase
    if (!fin) we = 1'b0;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_SCAN;
      S_SCAN: if (cnt_q == CW'(MAX_BLOCKS)) state_d = S_DONE;
      S_DONE: if (fin) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      count_q     <= '0;
      end_q       <= '1;
      bump_q      <= '0;
      used_q      <= '0;
      total_q     <= '0;
      reuse_q     <= '0;
      resz_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_xfer) cnt_q <= '0;
      else if (state_q == S_SCAN) cnt_q <= cnt_q + CW'(1);
      // configuration writes; heap_base only matters through the bump pointer
      if (cfg_we_i && (cfg_index_i == bfa_pkg::CfgHeapEnd)) end_q <= cfg_data_i;
      if (cfg_we_i && (cfg_index_i == bfa_pkg::CfgHeapBase) && (count_q == '0)) begin
        bump_q <= cfg_data_i;
      end else if (fin) begin
        bump_q <= bump_d;
      end
      if (fin) begin
        count_q <= count_d;
        used_q  <= used_d;
        total_q <= total_d;
        reuse_q <= reuse_d;
        resz_q  <= resz_d;
      end
      if (fin) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // command and result registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q <= '{op: bfa_pkg::op_e'(opcode_i), size: request_size_i,
                 addr: payload_address_i};
    end
    if (fin) begin
      result_address_o <= res_d;
      status_o         <= st_d;
      used_bytes_o     <= used_d;
      total_bytes_o    <= total_d;
      block_count_o    <= 7'(count_d);
      reuse_count_o    <= reuse_d;
      resize_count_o   <= resz_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== bench/best_fit_block_allocator_tb.sv =====
// testbench of best_fit_block_allocator: table-driven directed operations,
// then random allocate/free/resize traffic, all checked against a predictor
// depends on bfa_pkg and the allocator rtl
`timescale 1ns / 1ps

module best_fit_block_allocator_tb;

  localparam int unsigned NBLK = 64;
  localparam int unsigned HDR  = 16;
  localparam int unsigned RANDOM_ITEMS = 1630;

  typedef struct {
    logic [31:0]      addr;
    bfa_pkg::status_e status;
    logic [31:0]      used;
    logic [31:0]      total;
    logic [6:0]       count;
    logic [31:0]      reuses;
    logic [31:0]      resizes;
  } heap_result_t;

  typedef struct {
    bfa_pkg::op_e     op;
    logic [31:0]      size;
    logic [31:0]      addr;
    bit               fixed;
    logic [31:0]      want_addr;
    bfa_pkg::status_e want_status;
  } heap_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  opcode_i = '0;
  logic [31:0] request_size_i = '0;
  logic [31:0] payload_address_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] result_address_o;
  logic [2:0]  status_o;
  logic [31:0] used_bytes_o, total_bytes_o, reuse_count_o, resize_count_o;
  logic [6:0]  block_count_o;

  best_fit_block_allocator u_top (.*);

  always #6 clk_i = ~clk_i;

  // predictor copy of the heap table
  logic [31:0] blk_start [NBLK];
  logic [31:0] blk_size  [NBLK];
  bit          blk_free  [NBLK];
  int unsigned blk_count;
  logic [31:0] bump, used_sum, total_sum, reuse_sum, resize_sum;
  logic [31:0] base_reg, end_reg;

  heap_result_t pending_results[$];
  int          mismatches = 0;
  int          send_idle = 0, recv_idle = 0;
  int          result_seen = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic void heap_clear();
    blk_count = 0; base_reg = '0; end_reg = '1; bump = '0;
    used_sum = '0; total_sum = '0; reuse_sum = '0; resize_sum = '0;
  endfunction

  function automatic int find_block(logic [31:0] a);
    for (int i = 0; i < blk_count; i++)
      if (blk_start[i] + HDR == a) return i;
    return -1;
  endfunction

  // compute the next result and update the predicted table
  function automatic heap_result_t heap_apply(bfa_pkg::op_e op, logic [31:0] sz,
                                               logic [31:0] a);
    heap_result_t r;
    int b;
    logic [33:0] fin;
    r.addr = '0; r.status = bfa_pkg::ST_OK;
    case (op)
      bfa_pkg::OP_ALLOC: begin
        if (sz == 0) r.status = bfa_pkg::ST_ZERO;
        else begin
          b = -1;
          for (int i = blk_count - 1; i >= 0; i--)
            if (blk_free[i] && blk_size[i] >= sz &&
                (b < 0 || blk_size[i] < blk_size[b])) b = i;
          if (b >= 0) begin
            blk_free[b] = 0; used_sum += blk_size[b]; reuse_sum++;
            r.addr = blk_start[b] + HDR;
          end else begin
            fin = {2'b0, bump} + 34'(HDR) + {2'b0, sz};
            if (blk_count >= NBLK || fin > {2'b0, end_reg})
              r.status = bfa_pkg::ST_NO_ROOM;
            else begin
              blk_start[blk_count] = bump; blk_size[blk_count] = sz;
              blk_free[blk_count] = 0;
              r.addr = bump + HDR;
              blk_count++; bump = fin[31:0];
              used_sum += sz; total_sum += sz;
            end
          end
        end
      end
      bfa_pkg::OP_FREE: begin
        b = find_block(a);
        if (b < 0) r.status = bfa_pkg::ST_UNKNOWN;
        else if (!blk_free[b]) begin
          blk_free[b] = 1; used_sum -= blk_size[b];
        end
      end
      bfa_pkg::OP_RESIZE: begin
        b = find_block(a);
        if (b < 0) r.status = bfa_pkg::ST_UNKNOWN;
        else if (b + 1 != blk_count) r.status = bfa_pkg::ST_NOT_NEW;
        else begin
          total_sum = total_sum - blk_size[b] + sz;
          if (!blk_free[b]) used_sum = used_sum - blk_size[b] + sz;
          blk_size[b] = sz; resize_sum++;
        end
      end
      default: ;
    endcase
    r.used = used_sum; r.total = total_sum; r.count = blk_count[6:0];
    r.reuses = reuse_sum; r.resizes = resize_sum;
    return r;
  endfunction

  // one register write; the task returns with write enable low again
  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == bfa_pkg::CfgHeapBase) begin
      base_reg = val;
      if (blk_count == 0) bump = val;
    end else end_reg = val;
    @(posedge clk_i);
  endtask

  // one transfer on the input side, with optional idle cycles before it;
  // valid stays up after the transfer until the next call or a drain
  task automatic send_item(input bfa_pkg::op_e op, input logic [31:0] sz,
                           input logic [31:0] a);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1; opcode_i <= op; request_size_i <= sz;
    payload_address_i <= a;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(heap_apply(op, sz, a));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (NBLK + 8) @(posedge clk_i);
  endtask

  // result side stall pattern
  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < recv_idle);

  // compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    heap_result_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 32'd1, 32'd0);
      end else begin
        w = pending_results.pop_front();
        result_seen++;
        if (result_address_o !== w.addr) report_mismatch("address", result_address_o, w.addr);
        if (status_o !== w.status) report_mismatch("status", status_o, w.status);
        if (used_bytes_o !== w.used) report_mismatch("used", used_bytes_o, w.used);
        if (total_bytes_o !== w.total) report_mismatch("total", total_bytes_o, w.total);
        if (block_count_o !== w.count) report_mismatch("count", block_count_o, w.count);
        if (reuse_count_o !== w.reuses) report_mismatch("reuses", reuse_count_o, w.reuses);
        if (resize_count_o !== w.resizes)
          report_mismatch("resizes", resize_count_o, w.resizes);
      end
    end
  end

  // pick a known payload address most of the time
  function automatic logic [31:0] some_address();
    int unsigned k;
    k = $urandom_range(9);
    if (blk_count != 0 && k < 6) return blk_start[$urandom_range(blk_count - 1)] + HDR;
    if (blk_count != 0 && k < 8) return blk_start[blk_count - 1] + HDR;
    return $urandom;
  endfunction

  function automatic logic [31:0] some_size();
    int unsigned k;
    k = $urandom_range(19);
    if (k == 0) return '0;
    if (k == 1) return $urandom;
    if (k < 5) return $urandom_range(4096);
    return $urandom_range(1, 96);
  endfunction

  heap_row_t directed[$];

  initial begin
    heap_result_t w;
    bfa_pkg::op_e op;
    int unsigned k;
    heap_clear();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table; expected address and status typed in where obvious
    directed = '{
      '{bfa_pkg::OP_QUERY,  32'd0,         32'd0,         1, 32'd0,    bfa_pkg::ST_OK},
      '{bfa_pkg::OP_ALLOC,  32'd0,         32'd0,         1, 32'd0,    bfa_pkg::ST_ZERO},
      '{bfa_pkg::OP_FREE,   32'd0,         32'hFFFF_FFFF, 1, 32'd0,    bfa_pkg::ST_UNKNOWN},
      '{bfa_pkg::OP_RESIZE, 32'd5,         32'd16,        1, 32'd0,    bfa_pkg::ST_UNKNOWN},
      '{bfa_pkg::OP_ALLOC,  32'd32,        32'd0,         1, 32'h1010, bfa_pkg::ST_OK},
      '{bfa_pkg::OP_ALLOC,  32'd8,         32'd0,         1, 32'h1040, bfa_pkg::ST_OK},
      '{bfa_pkg::OP_ALLOC,  32'd32,        32'd0,         1, 32'h1058, bfa_pkg::ST_OK},
      '{bfa_pkg::OP_RESIZE, 32'd1,         32'h1010,      1, 32'd0,    bfa_pkg::ST_NOT_NEW},
      '{bfa_pkg::OP_FREE,   32'd0,         32'h1010,      0, 32'd0,    bfa_pkg::ST_OK},
      '{bfa_pkg::OP_FREE,   32'd0,         32'h1010,      0, 32'd0,    bfa_pkg::ST_OK},
      '{bfa_pkg::OP_FREE,   32'd0,         32'h1058,      0, 32'd0,    bfa_pkg::ST_OK},
      '{bfa_pkg::OP_ALLOC,  32'd20,        32'd0,         1, 32'h1058, bfa_pkg::ST_OK},
      '{bfa_pkg::OP_RESIZE, 32'd0,         32'h1058,      0, 32'd0,    bfa_pkg::ST_OK},
      '{bfa_pkg::OP_RESIZE, 32'hFFFF_FFFF, 32'h1058,      0, 32'd0,    bfa_pkg::ST_OK},
      '{bfa_pkg::OP_RESIZE, 32'd40,        32'h1058,      0, 32'd0,    bfa_pkg::ST_OK},
      '{bfa_pkg::OP_ALLOC,  32'hFFFF_FFFF, 32'd0,         1, 32'd0,    bfa_pkg::ST_NO_ROOM},
      '{bfa_pkg::OP_ALLOC,  32'h0001_0000, 32'd0,         1, 32'd0,    bfa_pkg::ST_NO_ROOM},
      '{bfa_pkg::OP_ALLOC,  32'd30,        32'd0,         1, 32'h1010, bfa_pkg::ST_OK},
      '{bfa_pkg::OP_QUERY,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'd0,    bfa_pkg::ST_OK}
    };
    write_reg(bfa_pkg::CfgHeapBase, 32'h1000);
    write_reg(bfa_pkg::CfgHeapEnd, 32'h2000);
    for (int i = 0; i < directed.size(); i++) begin
      send_item(directed[i].op, directed[i].size, directed[i].addr);
      if (directed[i].fixed) begin
        w = pending_results[$];
        if (w.addr !== directed[i].want_addr || w.status !== directed[i].want_status)
          report_mismatch("directed row", i, w.status);
      end
    end
    drain();

    // random phases with different idle patterns and heap limits
    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 7 : (phase == 1) ? 74 : 0;
      recv_idle = (phase == 0) ? 74 : (phase == 1) ? 7 : 0;
      // heap_base only reloads the pointer before any block exists
      write_reg(bfa_pkg::CfgHeapBase, $urandom);
      write_reg(bfa_pkg::CfgHeapEnd,
                (phase == 2) ? 32'hFFFF_FFFF : (phase == 1) ? 32'h0 : $urandom);
      if (phase == 1) write_reg(bfa_pkg::CfgHeapEnd, base_reg + 32'h0000_8000);
      for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
        k = $urandom_range(9);
        op = (k < 5) ? bfa_pkg::OP_ALLOC : (k < 8) ? bfa_pkg::OP_FREE :
             (k < 9) ? bfa_pkg::OP_RESIZE : bfa_pkg::OP_QUERY;
        send_item(op, some_size(), some_address());
        if (n == 200) drain();
      end
      drain();
    end

    $display("covered %0d results over directed rows and three idle patterns,",
             result_seen);
    $display("with heap limits from tight to open and a full block table");
    if (mismatches == 0) $display("PASS best_fit_block_allocator");
    else $display("FAIL best_fit_block_allocator");
    $finish;
  end

  initial begin
    #90ms;
    $display("FAIL best_fit_block_allocator");
    $finish;
  end

endmodule
